// File: rtl/core/constant_fraction_timing_unit_assert.svh
// Assertion macros for the constant fraction timing unit.
// Used by modules that check their own control logic; needs clock and reset in scope.
`ifndef CONSTANT_FRACTION_TIMING_UNIT_ASSERT_SVH
`define CONSTANT_FRACTION_TIMING_UNIT_ASSERT_SVH

// same-cycle implication
`define CFTU_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cftu check failed");

// next-cycle implication
`define CFTU_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cftu check failed");

`endif

// File: rtl/core/cftu_pkg.sv
// Shared types and constants of the constant fraction timing unit.
// No dependencies.
package cftu_pkg;

   localparam int RecordMaxDefault = 1024;
   localparam int DelayMaxDefault  = 64;
   localparam int SW = 15;   // sample width after polarity handling (0..16384)

   typedef enum logic [2:0] {
      CSR_BASELINE  = 3'd0,
      CSR_THRESHOLD = 3'd1,
      CSR_DELAY     = 3'd2,
      CSR_ATTEN     = 3'd3,
      CSR_POLARITY  = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      BK_RUN,
      BK_EDGE_GO,
      BK_EDGE_WAIT,
      BK_CFD_GO,
      BK_CFD_WAIT,
      BK_SEND
   } back_state_type;

   typedef struct packed {
      logic [SW-1:0] smp;
      logic          last;
      logic          zero_delay;
      logic          use_delay;
      logic [SW-1:0] delayed;
   } item_type;

   typedef struct packed {
      logic [17:0]        cfd_time;
      logic               cfd_found;
      logic [17:0]        edge_time;
      logic               edge_found;
      logic               overflow;
      logic [13:0]        sample_min;
      logic signed [15:0] cfd_min;
      logic [14:0]        cfd_max;
      logic [9:0]         cfd_min_index;
      logic [9:0]         cfd_max_index;
   } rsp_type;

endpackage

// File: rtl/core/cftu_front.sv
// Front end: polarity handling, delay memory and sample classification.
// Depends on cftu_pkg.
module cftu_front import cftu_pkg::*; #(
   parameter int RECORD_MAX = RecordMaxDefault,
   parameter int DELAY_MAX  = DelayMaxDefault,
   localparam int IW = $clog2(RECORD_MAX),
   localparam int PW = $clog2(DELAY_MAX),
   localparam int DW = $clog2(DELAY_MAX + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   output logic          req_full,
   input  logic [13:0]   req_sample,
   input  logic          req_last,
   input  logic          pol,
   input  logic [DW-1:0] delay,
   output logic          q_push,
   input  logic          q_full,
   output item_type      q_item
);
   logic [SW-1:0] mem [DELAY_MAX];
   logic [IW-1:0] idx_ff, idx_in;
   logic [PW-1:0] wp_ff, wp_in, rd_addr;
   logic          v_ff, v_in;
   logic [SW-1:0] smp_ff, smp_cur;
   logic          last_ff, zd_ff, ud_ff;
   logic [SW-1:0] del_ff;
   logic          accept;

   assign req_full = v_ff && q_full;
   assign accept   = req_push && !req_full;
   assign smp_cur  = pol ? SW'(15'd16384 - {1'b0, req_sample}) : {1'b0, req_sample};

   always_comb begin
      if (32'(wp_ff) >= 32'(delay)) begin
         rd_addr = PW'(32'(wp_ff) - 32'(delay));
      end else begin
         rd_addr = PW'(32'(wp_ff) + DELAY_MAX - 32'(delay));
      end
      wp_in = (32'(wp_ff) == DELAY_MAX - 1) ? '0 : PW'(wp_ff + 1'b1);
      if (req_last) begin
         idx_in = '0;
      end else if (idx_ff < IW'(RECORD_MAX - 1)) begin
         idx_in = IW'(idx_ff + 1'b1);
      end else begin
         idx_in = idx_ff;
      end
      v_in = accept || (v_ff && q_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff   <= 1'b0;
         idx_ff <= '0;
         wp_ff  <= '0;
      end else begin
         v_ff <= v_in;
         if (accept) begin
            idx_ff <= idx_in;
            wp_ff  <= wp_in;
         end
      end
   end

   // memory: write the new sample, read the one delay beats back
   always_ff @(posedge clock) begin
      if (accept) begin
         mem[wp_ff] <= smp_cur;
         del_ff     <= mem[rd_addr];
         smp_ff     <= smp_cur;
         last_ff    <= req_last;
         zd_ff      <= (delay == '0);
         ud_ff      <= (32'(idx_ff) >= 32'(delay));
      end
   end

   assign q_push = v_ff;
   assign q_item = '{smp: smp_ff, last: last_ff, zero_delay: zd_ff, use_delay: ud_ff,
                     delayed: del_ff};
endmodule

// File: rtl/core/cftu_queue.sv
// Two-entry queue between front and back ends.
// Depends on cftu_pkg.
module cftu_queue import cftu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  item_type din,
   input  logic     pop,
   output logic     empty,
   output item_type dout
);
   item_type   mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full    = cnt_ff == 2'd2;
   assign empty   = cnt_ff == 2'd0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (do_push) wp_ff <= ~wp_ff;
         if (do_pop)  rp_ff <= ~rp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wp_ff] <= din;
      end
   end
endmodule

// File: rtl/core/cftu_div.sv
// Restoring divider giving 8 fraction bits of num/den, num < den, one bit a cycle.
// Depends on cftu_pkg.
module cftu_div import cftu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [16:0] num,
   input  logic [16:0] den,
   output logic        busy,
   output logic [7:0]  quot
);
   logic [17:0] rem_ff, rem_in, shl;
   logic [16:0] den_ff;
   logic [7:0]  q_ff, q_in;
   logic [3:0]  cnt_ff, cnt_in;

   assign busy = cnt_ff != 4'd0;
   assign quot = q_ff;

   always_comb begin
      shl    = {rem_ff[16:0], 1'b0};
      rem_in = shl;
      q_in   = {q_ff[6:0], 1'b0};
      if (shl >= {1'b0, den_ff}) begin
         rem_in = shl - {1'b0, den_ff};
         q_in   = {q_ff[6:0], 1'b1};
      end
      cnt_in = cnt_ff - 4'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= 4'd8;
      end else if (busy) begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, num};
         den_ff <= den;
         q_ff   <= '0;
      end else if (busy) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end
endmodule

// File: rtl/core/cftu_back.sv
// Back end: CFD value, extremes, arming, crossings, record close and result register.
// Depends on cftu_pkg, cftu_div and constant_fraction_timing_unit_assert.svh.
module cftu_back import cftu_pkg::*; #(
   parameter int RECORD_MAX = RecordMaxDefault,
   localparam int IW = $clog2(RECORD_MAX)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_empty,
   input  item_type      q_item,
   output logic          q_pop,
   input  logic [SW-1:0] base,
   input  logic [13:0]   thr,
   input  logic [8:0]    atten,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output rsp_type       rsp
);
   back_state_type state_ff, state_in;

   logic [IW-1:0]      idx_ff, cross_idx_ff, edge_idx_ff, min_idx_ff, max_idx_ff;
   logic               armed_ff, cross_ff, edge_ff, edge_fen_ff, ovf_ff;
   logic signed [16:0] prev_cfd_ff, c0_ff, c1_ff;
   logic [SW-1:0]      prev_s_ff;
   logic [15:0]        edge_num_ff;
   logic [16:0]        edge_den_ff;
   logic [13:0]        smin_ff;
   logic signed [15:0] cmin_ff;
   logic [14:0]        cmax_ff;
   logic [7:0]         edge_frac_ff;
   logic               out_v_ff;
   rsp_type            out_ff, out_in;

   logic signed [15:0] d_sb, bs, inv;
   logic signed [25:0] prod;
   logic [25:0]        mag;
   logic [17:0]        rnd;
   logic signed [17:0] rterm, cfd_w;
   logic signed [16:0] cfd, lval;
   logic               arm_hit, edge_hit;
   logic               div_start, div_busy;
   logic [16:0]        div_num, div_den;
   logic [7:0]         div_q, cfd_frac;
   logic [IW-1:0]      idx_next;
   logic               send;

   assign d_sb  = $signed({1'b0, q_item.smp}) - $signed({1'b0, base});
   assign prod  = d_sb * $signed({1'b0, atten});
   assign mag   = prod[25] ? 26'(-prod) : prod;
   assign rnd   = 18'((mag + 26'd128) >> 8);
   assign rterm = prod[25] ? -$signed(rnd) : $signed(rnd);
   assign inv   = !q_item.use_delay ? 16'sd0 :
                  $signed({1'b0, base}) -
                  $signed({1'b0, q_item.zero_delay ? q_item.smp : q_item.delayed});
   assign cfd_w = rterm + 18'(inv);
   assign cfd   = cfd_w[16:0];

   assign bs       = $signed({1'b0, base}) - $signed({1'b0, q_item.smp});
   assign arm_hit  = bs > $signed({2'b0, thr});
   assign edge_hit = !edge_ff && idx_ff != '0 && arm_hit;
   assign lval     = $signed({3'b0, thr}) - $signed({2'b0, base}) + $signed({2'b0, prev_s_ff});
   assign idx_next = (idx_ff < IW'(RECORD_MAX - 1)) ? IW'(idx_ff + 1'b1) : idx_ff;

   assign q_pop     = state_ff == BK_RUN && !q_empty;
   assign rsp_empty = !out_v_ff;
   assign rsp       = out_ff;
   assign send      = state_ff == BK_SEND && !out_v_ff;

   always_comb begin
      div_start = 1'b0;
      div_num   = edge_fen_ff ? {1'b0, edge_num_ff} : '0;
      div_den   = edge_den_ff;
      state_in  = state_ff;
      unique case (state_ff)
         BK_RUN: begin
            if (q_pop && q_item.last) state_in = BK_EDGE_GO;
         end
         BK_EDGE_GO: begin
            div_start = 1'b1;
            state_in  = BK_EDGE_WAIT;
         end
         BK_EDGE_WAIT: begin
            if (!div_busy) state_in = BK_CFD_GO;
         end
         BK_CFD_GO: begin
            div_start = 1'b1;
            div_num   = 17'(-c0_ff);
            div_den   = 17'(c1_ff - c0_ff);
            state_in  = BK_CFD_WAIT;
         end
         BK_CFD_WAIT: begin
            if (!div_busy) state_in = BK_SEND;
         end
         BK_SEND: begin
            if (send) state_in = BK_RUN;
         end
         default: state_in = BK_RUN;
      endcase
   end

   cftu_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quot  (div_q)
   );

   always_comb begin
      cfd_frac          = c0_ff[16] ? div_q : 8'd0;
      out_in            = '0;
      out_in.cfd_found  = cross_ff;
      if (cross_ff && cross_idx_ff != '0) begin
         out_in.cfd_time = 18'((32'(IW'(cross_idx_ff - 1'b1)) << 8) | 32'(cfd_frac));
      end
      out_in.edge_found = edge_ff;
      if (edge_ff) begin
         out_in.edge_time = 18'((32'(IW'(edge_idx_ff - 1'b1)) << 8) | 32'(edge_frac_ff));
      end
      out_in.overflow      = ovf_ff;
      out_in.sample_min    = smin_ff;
      out_in.cfd_min       = cmin_ff;
      out_in.cfd_max       = cmax_ff;
      out_in.cfd_min_index = 10'(min_idx_ff);
      out_in.cfd_max_index = 10'(max_idx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_RUN;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (send) begin
            out_v_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (send) out_ff <= out_in;
      if (state_ff == BK_EDGE_WAIT && !div_busy) begin
         edge_frac_ff <= edge_fen_ff ? div_q : 8'd0;
      end
   end

   // record state: clear on reset and after the result is loaded
   always_ff @(posedge clock) begin
      if (reset || send) begin
         idx_ff       <= '0;
         armed_ff     <= 1'b0;
         cross_ff     <= 1'b0;
         edge_ff      <= 1'b0;
         edge_fen_ff  <= 1'b0;
         ovf_ff       <= 1'b0;
         prev_cfd_ff  <= '0;
         c0_ff        <= '0;
         c1_ff        <= '0;
         cross_idx_ff <= '0;
         prev_s_ff    <= '0;
         edge_idx_ff  <= '0;
         edge_num_ff  <= '0;
         edge_den_ff  <= '0;
         smin_ff      <= 14'd16383;
         cmin_ff      <= '0;
         cmax_ff      <= '0;
         min_idx_ff   <= '0;
         max_idx_ff   <= '0;
      end else if (q_pop) begin
         if ({1'b0, q_item.smp} < {2'b0, smin_ff}) smin_ff <= q_item.smp[13:0];
         if (q_item.smp == '0) ovf_ff <= 1'b1;
         if (edge_hit) begin
            edge_ff     <= 1'b1;
            edge_idx_ff <= idx_ff;
            edge_fen_ff <= lval > 17'sd0;
            edge_num_ff <= lval[15:0];
            edge_den_ff <= 17'({1'b0, prev_s_ff} - {1'b0, q_item.smp});
         end
         if (arm_hit) armed_ff <= 1'b1;
         if (!cross_ff && (armed_ff || arm_hit) && cfd > 17'sd0) begin
            cross_ff     <= 1'b1;
            cross_idx_ff <= idx_ff;
            c0_ff        <= prev_cfd_ff;
            c1_ff        <= cfd;
         end
         if (cfd < 17'(cmin_ff)) begin
            cmin_ff    <= (cfd < -17'sd32768) ? -16'sd32768 : cfd[15:0];
            min_idx_ff <= idx_ff;
         end
         if (cfd > $signed({2'b0, cmax_ff})) begin
            cmax_ff    <= (cfd > 17'sd32767) ? 15'd32767 : cfd[14:0];
            max_idx_ff <= idx_ff;
         end
         prev_cfd_ff <= cfd;
         prev_s_ff   <= q_item.smp;
         idx_ff      <= idx_next;
      end
   end

   `include "constant_fraction_timing_unit_assert.svh"

   `CFTU_ASSERT_NXT(a_hold_result, out_v_ff && !rsp_pop, out_v_ff)
   `CFTU_ASSERT_IMP(a_div_idle_at_start, div_start, !div_busy)
   `CFTU_ASSERT_IMP(a_pop_only_running, q_pop, state_ff == BK_RUN)
   `CFTU_ASSERT_NXT(a_last_closes, q_pop && q_item.last, state_ff == BK_EDGE_GO)
endmodule

// File: rtl/core/constant_fraction_timing_unit.sv
// Top level of the constant fraction timing unit: CSR file and front/queue/back wiring.
// Depends on cftu_pkg, cftu_front, cftu_queue, cftu_back.
//
//   channel  ports                      handshake
//   req      sample, last               push / full
//   rsp      cfd/edge times, extremes   empty / pop
//   csr      index, data                valid / ready (ready always high)
//
// The back end pops a queued sample whenever it runs; push stays open at one sample a cycle
// while it runs. Closing a record takes two 8-step divisions in the shared divider;
// push stalls once front stage and queue fill.
// The result register frees the back end only when the previous result is popped.
// Reset is synchronous; no clearing pass is needed.
module constant_fraction_timing_unit import cftu_pkg::*; #(
   parameter int RECORD_MAX = RecordMaxDefault,
   parameter int DELAY_MAX  = DelayMaxDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [13:0]        req_sample,
   input  logic               req_last,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [17:0]        rsp_cfd_time,
   output logic               rsp_cfd_found,
   output logic [17:0]        rsp_edge_time,
   output logic               rsp_edge_found,
   output logic               rsp_overflow,
   output logic [13:0]        rsp_sample_min,
   output logic signed [15:0] rsp_cfd_min,
   output logic [14:0]        rsp_cfd_max,
   output logic [9:0]         rsp_cfd_min_index,
   output logic [9:0]         rsp_cfd_max_index,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [13:0]        csr_data
);
   localparam int DW = $clog2(DELAY_MAX + 1);

   logic [13:0]   base_ff, thr_ff;
   logic [5:0]    delay_ff;
   logic [8:0]    atten_ff;
   logic          pol_ff;
   logic [SW-1:0] base_eff;
   logic [DW-1:0] delay_eff;
   logic [8:0]    atten_eff;
   logic          q_push, q_full, q_pop, q_empty;
   item_type      q_din, q_dout;
   rsp_type       rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= 14'd0;
         thr_ff   <= 14'd100;
         delay_ff <= 6'd4;
         atten_ff <= 9'd64;
         pol_ff   <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BASELINE:  base_ff  <= csr_data;
            CSR_THRESHOLD: thr_ff   <= csr_data;
            CSR_DELAY:     delay_ff <= csr_data[5:0];
            CSR_ATTEN:     atten_ff <= csr_data[8:0];
            CSR_POLARITY:  pol_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign base_eff  = pol_ff ? SW'(15'd16384 - {1'b0, base_ff}) : {1'b0, base_ff};
   assign delay_eff = (32'(delay_ff) > DELAY_MAX) ? DW'(DELAY_MAX) : DW'(delay_ff);
   assign atten_eff = (atten_ff > 9'd256) ? 9'd256 : atten_ff;

   cftu_front #(.RECORD_MAX(RECORD_MAX), .DELAY_MAX(DELAY_MAX)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_sample (req_sample),
      .req_last   (req_last),
      .pol        (pol_ff),
      .delay      (delay_eff),
      .q_push     (q_push),
      .q_full     (q_full),
      .q_item     (q_din)
   );

   cftu_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .full  (q_full),
      .din   (q_din),
      .pop   (q_pop),
      .empty (q_empty),
      .dout  (q_dout)
   );

   cftu_back #(.RECORD_MAX(RECORD_MAX)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_item    (q_dout),
      .q_pop     (q_pop),
      .base      (base_eff),
      .thr       (thr_ff),
      .atten     (atten_eff),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_cfd_time      = rsp.cfd_time;
   assign rsp_cfd_found     = rsp.cfd_found;
   assign rsp_edge_time     = rsp.edge_time;
   assign rsp_edge_found    = rsp.edge_found;
   assign rsp_overflow      = rsp.overflow;
   assign rsp_sample_min    = rsp.sample_min;
   assign rsp_cfd_min       = rsp.cfd_min;
   assign rsp_cfd_max       = rsp.cfd_max;
   assign rsp_cfd_min_index = rsp.cfd_min_index;
   assign rsp_cfd_max_index = rsp.cfd_max_index;
endmodule

// File: sim/testbench.sv
// Self-checking testbench for the constant fraction timing unit.
// Depends on cftu_pkg and constant_fraction_timing_unit; predicts each record result
// from its own model of the CFD and edge timing and checks every popped beat.
module testbench;
   import cftu_pkg::*;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_push = 0;
   logic               req_full;
   logic [13:0]        req_sample = 0;
   logic               req_last = 0;
   logic               rsp_empty;
   logic               rsp_pop = 0;
   logic [17:0]        rsp_cfd_time;
   logic               rsp_cfd_found;
   logic [17:0]        rsp_edge_time;
   logic               rsp_edge_found;
   logic               rsp_overflow;
   logic [13:0]        rsp_sample_min;
   logic signed [15:0] rsp_cfd_min;
   logic [14:0]        rsp_cfd_max;
   logic [9:0]         rsp_cfd_min_index;
   logic [9:0]         rsp_cfd_max_index;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic [2:0]         csr_index = CSR_BASELINE;
   logic [13:0]        csr_data = 0;

   constant_fraction_timing_unit u_dut (.*);

   always #5 clock = ~clock;

   // register copies
   int cfg_baseline = 0, cfg_threshold = 100, cfg_delay = 4, cfg_atten = 64, cfg_polarity = 0;

   // record state of the timing model
   int smp_hist [64];
   int smp_idx, prev_smp, prev_cfd, cross_idx, cross_c0, cross_c1, edge_tm;
   int min_smp, min_cfd, max_cfd, min_cfd_idx, max_cfd_idx;
   bit armed, crossed, edge_hit, zero_seen;

   rsp_type timing_results [$];
   int      errors = 0;
   int      send_idle_pct = 10, pop_idle_pct = 10;
   int      hold_request = 0;

   task automatic clear_record();
      smp_idx = 0; prev_smp = 0; prev_cfd = 0; cross_idx = 0; cross_c0 = 0; cross_c1 = 0;
      edge_tm = 0; min_smp = 16383; min_cfd = 0; max_cfd = 0; min_cfd_idx = 0;
      max_cfd_idx = 0; armed = 0; crossed = 0; edge_hit = 0; zero_seen = 0;
   endtask

   function automatic int round_q8(int v);
      if (v >= 0) return (v + 128) >>> 8;
      return -((-v + 128) >>> 8);
   endfunction

   task automatic time_sample(int raw, bit lst);
      int s, b, thr, d, a, cfd, inv, h, l, frac, ctime;
      rsp_type r;
      s = raw; b = cfg_baseline;
      if (cfg_polarity != 0) begin
         s = 16384 - s;
         b = 16384 - b;
      end
      thr = cfg_threshold; d = cfg_delay;
      a = (cfg_atten > 256) ? 256 : cfg_atten;
      if (s < min_smp) min_smp = s;
      if (s == 0) zero_seen = 1;
      if (!edge_hit && smp_idx > 0 && b - s > thr) begin
         h = b - s - thr;
         l = thr - b + prev_smp;
         frac = (l > 0) ? (l * 256) / (h + l) : 0;
         edge_tm = ((smp_idx - 1) << 8) + frac;
         edge_hit = 1;
      end
      inv = 0;
      if (smp_idx >= d) inv = b - ((d == 0) ? s : smp_hist[d-1]);
      cfd = round_q8((s - b) * a) + inv;
      if (s < b - thr) armed = 1;
      if (!crossed && armed && cfd > 0) begin
         crossed = 1; cross_idx = smp_idx; cross_c0 = prev_cfd; cross_c1 = cfd;
      end
      if (cfd < min_cfd) begin
         min_cfd = (cfd < -32768) ? -32768 : cfd;
         min_cfd_idx = smp_idx;
      end
      if (cfd > max_cfd) begin
         max_cfd = (cfd > 32767) ? 32767 : cfd;
         max_cfd_idx = smp_idx;
      end
      prev_cfd = cfd; prev_smp = s;
      for (int k = 63; k > 0; k--) smp_hist[k] = smp_hist[k-1];
      smp_hist[0] = s;
      if (smp_idx < 1023) smp_idx++;
      if (lst) begin
         ctime = 0;
         if (crossed && cross_idx > 0) begin
            frac = (cross_c0 < 0) ? (-cross_c0 * 256) / (cross_c1 - cross_c0) : 0;
            ctime = ((cross_idx - 1) << 8) + frac;
         end
         r.cfd_time = ctime[17:0];
         r.cfd_found = crossed;
         r.edge_time = edge_tm[17:0];
         r.edge_found = edge_hit;
         r.overflow = zero_seen;
         r.sample_min = (min_smp > 16383) ? 14'd16383 : min_smp[13:0];
         r.cfd_min = min_cfd[15:0];
         r.cfd_max = max_cfd[14:0];
         r.cfd_min_index = min_cfd_idx[9:0];
         r.cfd_max_index = max_cfd_idx[9:0];
         timing_results.push_back(r);
         clear_record();
      end
   endtask

   task automatic check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         errors++;
      end
   endtask

   // result side: check each popped beat, then pick the next pop level
   always @(posedge clock) begin
      rsp_type e;
      int hold_left;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (timing_results.size() == 0) begin
            $error("result beat with no pending record");
            errors++;
         end else begin
            e = timing_results.pop_front();
            check_field("cfd_time", e.cfd_time, rsp_cfd_time);
            check_field("cfd_found", e.cfd_found, rsp_cfd_found);
            check_field("edge_time", e.edge_time, rsp_edge_time);
            check_field("edge_found", e.edge_found, rsp_edge_found);
            check_field("overflow", e.overflow, rsp_overflow);
            check_field("sample_min", e.sample_min, rsp_sample_min);
            check_field("cfd_min", int'($signed(e.cfd_min)), int'(rsp_cfd_min));
            check_field("cfd_max", e.cfd_max, rsp_cfd_max);
            check_field("cfd_min_index", e.cfd_min_index, rsp_cfd_min_index);
            check_field("cfd_max_index", e.cfd_max_index, rsp_cfd_max_index);
         end
      end
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) hold_left--;
      rsp_pop <= (hold_left == 0) && ($urandom_range(99) >= pop_idle_pct);
   end

   task automatic send_sample(int raw, bit lst);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 0;
         @(posedge clock);
      end
      req_push <= 1;
      req_sample <= raw[13:0];
      req_last <= lst;
      @(posedge clock);
      while (req_full) @(posedge clock);
      time_sample(raw, lst);
   endtask

   task automatic drain();
      req_push <= 0;
      while (timing_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, int value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value[13:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      case (idx)
         CSR_BASELINE:  cfg_baseline = value & 16'h3fff;
         CSR_THRESHOLD: cfg_threshold = value & 16'h3fff;
         CSR_DELAY:     cfg_delay = value & 6'h3f;
         CSR_ATTEN:     cfg_atten = value & 9'h1ff;
         CSR_POLARITY:  cfg_polarity = value & 1;
         default: ;
      endcase
   endtask

   task automatic set_config(int bl, int thr, int dly, int att, int pol);
      csr_write(CSR_BASELINE, bl);
      csr_write(CSR_THRESHOLD, thr);
      csr_write(CSR_DELAY, dly);
      csr_write(CSR_ATTEN, att);
      csr_write(CSR_POLARITY, pol);
   endtask

   // triangular pulse on the baseline with noise; polarity decides direction
   task automatic send_pulse(int len);
      int start, rise, fall, amp, depth, v;
      start = $urandom_range(len / 2);
      rise = $urandom_range(1, 5);
      fall = $urandom_range(3, 15);
      amp = $urandom_range(16383);
      for (int i = 0; i < len; i++) begin
         depth = 0;
         if (i >= start && i < start + rise) depth = amp * (i - start + 1) / rise;
         else if (i >= start + rise && i < start + rise + fall)
            depth = amp - amp * (i - start - rise) / fall;
         v = cfg_polarity ? cfg_baseline + depth : cfg_baseline - depth;
         v += $urandom_range(40) - 20;
         if (v < 0) v = 0;
         if (v > 16383) v = 16383;
         send_sample(v, i == len - 1);
      end
   endtask

   task automatic test_defaults();
      send_pulse(30);
      send_sample(0, 0);
      send_sample(16383, 1);
      drain();
   endtask

   task automatic test_extremes();
      set_config(16383, 0, 63, 256, 0);
      send_sample(16383, 0);
      send_sample(0, 0);
      send_sample(0, 0);
      send_sample(16383, 1);
      drain();
      // edge already past threshold on the sample before: no fraction
      set_config(8000, 100, 2, 511, 0);
      send_sample(1000, 0);
      send_sample(900, 0);
      send_sample(8000, 1);
      drain();
   endtask

   task automatic test_first_sample_crossing();
      set_config(10000, 50, 0, 128, 0);
      send_sample(2000, 0);
      send_sample(12000, 1);
      send_sample(3000, 1);
      drain();
   endtask

   task automatic test_positive_polarity();
      set_config(0, 200, 5, 77, 1);
      send_sample(0, 0);
      send_sample(16383, 0);
      send_pulse(20);
      drain();
      set_config(2000, 200, 5, 77, 1);
      send_pulse(25);
      drain();
   endtask

   task automatic test_long_record();
      set_config(9000, 300, 7, 100, 0);
      for (int i = 0; i < 1100; i++)
         send_sample((i % 97 == 50) ? 1000 : 9000 + $urandom_range(30), i == 1099);
      drain();
   endtask

   task automatic test_random(int target);
      int sent, len;
      sent = 0;
      while (sent < target) begin
         set_config($urandom_range(16383), $urandom_range(3) == 0 ? $urandom_range(16383)
                    : $urandom_range(500), $urandom_range(63), $urandom_range(511),
                    $urandom_range(1));
         send_idle_pct = ($urandom_range(4) == 0) ? 0 : 10;
         pop_idle_pct = ($urandom_range(4) == 0) ? 0 : 10;
         for (int r = 0; r < 4; r++) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(1, 4) : $urandom_range(8, 60);
            if ($urandom_range(4) == 0) begin
               for (int i = 0; i < len; i++) send_sample($urandom_range(16383), i == len - 1);
            end else begin
               send_pulse(len);
            end
            sent += len;
         end
         drain();
      end
      send_idle_pct = 10;
      pop_idle_pct = 10;
   endtask

   task automatic test_backpressure();
      set_config(12000, 100, 3, 90, 0);
      send_idle_pct = 0;
      hold_request = 400;
      for (int r = 0; r < 12; r++) send_pulse(3);
      send_idle_pct = 10;
      drain();
   endtask

   task automatic test_pause();
      set_config(11000, 150, 6, 200, 0);
      send_pulse(15);
      req_push <= 0;
      while (timing_results.size() != 0) @(posedge clock);
      send_pulse(15);
      drain();
   endtask

   initial begin
      clear_record();
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_defaults();
      test_extremes();
      test_first_sample_crossing();
      test_positive_polarity();
      test_long_record();
      test_backpressure();
      test_pause();
      test_random(150);
      if (errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
